>>> hdl/ctcm_pkg.sv
// Shared types, constants and constant-divisor helpers for the crystal to
// trigger cell map. No dependencies.
package ctcm_pkg;

  // Crystal number range and region boundaries (zero-based crystal offset)
  localparam logic [13:0] N_CRYSTALS = 14'd8736;
  localparam logic [13:0] FWD_END    = 14'd1152;
  localparam logic [13:0] BAR_END    = 14'd7776;

  // Small divisors and their 10-bit reciprocals, floor(1024 / d)
  localparam logic [3:0] DIV3       = 4'd3;
  localparam logic [3:0] DIV5       = 4'd5;
  localparam logic [3:0] DIV9       = 4'd9;
  localparam logic [9:0] DIV3_RECIP = 10'd341;
  localparam logic [9:0] DIV5_RECIP = 10'd204;
  localparam logic [9:0] DIV9_RECIP = 10'd113;

  typedef struct packed {
    logic [9:0] quo;
    logic [3:0] rem;
  } divmod_t;

  // Trigger cell result handed from the cell stage to the ring stage
  typedef struct packed {
    logic [9:0] cell_id;
    logic       sub_index;
    logic       range_error;
  } cell_t;

  // Quotient and remainder of a 10-bit value by a small constant: the
  // reciprocal estimate is low by at most one, so one correction step fixes it.
  function automatic divmod_t divmod_small(input logic [9:0] v, input logic [3:0] d,
                                           input logic [9:0] m);
    logic [19:0] prod;
    logic [9:0]  q;
    logic [9:0]  r;
    divmod_t     res;
    prod = {10'd0, v} * {10'd0, m};
    q = prod[19:10];
    r = v - q * {6'd0, d};
    if (r >= {6'd0, d}) begin
      q = q + 10'd1;
      r = r - {6'd0, d};
    end
    res.quo = q;
    res.rem = r[3:0];
    return res;
  endfunction

endpackage

>>> hdl/crystal_to_trigger_cell_map_unit.sv
// Path: a crystal passes through the input, cell and result registers, in that order.
// Throughput: one crystal per cycle while out_ready does not stall; cell and ring logic are combinational.
// Any stage advances when the stage after it is empty or moving on.
// Reset: synchronous, active low; clears the stage valid bits only.
// Top level of the crystal to trigger cell map. Depends on ctcm_pkg,
// ctcm_cell_calc and ctcm_ring_calc.
module crystal_to_trigger_cell_map_unit import ctcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] in_crystal_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_cell_id,
  output logic        out_sub_index,
  output logic [4:0]  out_theta_index,
  output logic [5:0]  out_phi_index,
  output logic        out_range_error
);

  logic        s1_valid_r;
  logic [13:0] s1_id_r;
  logic        s2_valid_r;
  cell_t       s2_cell_r;
  cell_t       s2_cell_nxt;
  logic        out_valid_r;
  logic [4:0]  theta_nxt;
  logic [5:0]  phi_nxt;
  logic        out_adv;
  logic        s2_adv;

  // Stage enables: a stage moves when the next one can take it
  assign out_adv  = ~out_valid_r | out_ready;
  assign s2_adv   = ~s2_valid_r | out_adv;
  assign in_ready = ~s1_valid_r | s2_adv;

  ctcm_cell_calc u_cell (
    .crystal_id (s1_id_r),
    .cell_res   (s2_cell_nxt)
  );

  ctcm_ring_calc u_ring (
    .cell_res    (s2_cell_r),
    .theta_index (theta_nxt),
    .phi_index   (phi_nxt)
  );

  // Input register: take a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_id_r <= in_crystal_id;
    end
  end

  // Cell register: hold while the result register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_cell_r <= s2_cell_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid_r) begin
      out_cell_id     <= s2_cell_r.cell_id;
      out_sub_index   <= s2_cell_r.sub_index;
      out_range_error <= s2_cell_r.range_error;
      out_theta_index <= theta_nxt;
      out_phi_index   <= phi_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_cell_id == 10'd0 && !out_sub_index &&
      out_theta_index == 5'd0 && out_phi_index == 6'd0))
    else $error("range error result carries nonzero fields");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |-> (out_cell_id >= 10'd1 && out_cell_id <= 10'd576 &&
      out_theta_index <= 5'd16 && out_phi_index <= 6'd35))
    else $error("mapped result outside cell, ring or sector range");

  a_take_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted crystal lost at input register");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_adv) |=> (s2_valid_r && $stable(s2_cell_r)))
    else $error("stalled cell stage changed");
`endif

endmodule

>>> hdl/ctcm_cell_calc.sv
// Crystal number to trigger cell number, sub-group bit and range flag.
// Depends on ctcm_pkg.
module ctcm_cell_calc import ctcm_pkg::*; (
  input  logic [13:0] crystal_id,
  output cell_t       cell_res
);

  // Ring rule with a period of nine crystals: groups of five and four
  function automatic logic [4:0] nine_group(input logic [9:0] v);
    divmod_t dm;
    dm = divmod_small(v, DIV9, DIV9_RECIP);
    return {dm.quo[3:0], (dm.rem >= 4'd5)};
  endfunction

  logic [13:0] x;
  logic        err;
  logic [9:0]  fwd_tc;
  logic [9:0]  bar_tc;
  logic [9:0]  bwd_tc;
  logic        sub_bit;

  assign x   = crystal_id - 14'd1;
  assign err = (crystal_id == 14'd0) || (crystal_id > N_CRYSTALS);

  // Forward endcap
  always_comb begin
    divmod_t    dm;
    logic [4:0] e;
    logic [9:0] even_add;
    logic [9:0] odd_add;
    logic       pair;
    logic [13:0] d;
    dm       = '0;
    e        = '0;
    even_add = 10'd2;
    odd_add  = 10'd3;
    pair     = 1'b1;
    fwd_tc   = '0;
    d        = '0;
    if (x < 14'd48) begin
      pair   = 1'b0;
      dm     = divmod_small(x[9:0], DIV3, DIV3_RECIP);
      fwd_tc = dm.quo * 10'd5 + 10'd1;
    end else if (x < 14'd96) begin
      pair   = 1'b0;
      d      = x - 14'd48;
      dm     = divmod_small(d[9:0], DIV3, DIV3_RECIP);
      fwd_tc = dm.quo * 10'd5 + 10'd1;
    end else if (x < 14'd160) begin
      pair   = 1'b0;
      d      = x - 14'd96;
      fwd_tc = {2'd0, d[9:2]} * 10'd5 + 10'd1;
    end else if (x < 14'd224) begin
      pair   = 1'b0;
      d      = x - 14'd160;
      fwd_tc = {2'd0, d[9:2]} * 10'd5 + 10'd1;
    end else if (x < 14'd288) begin
      d = x - 14'd224;
      e = d[5:1];
    end else if (x < 14'd672) begin
      d  = x - 14'd288;
      dm = divmod_small(d[9:0], DIV3, DIV3_RECIP);
      e  = dm.quo[4:0];
    end else if (x < 14'd864) begin
      d        = x - 14'd672;
      dm       = divmod_small(d[9:0], DIV3, DIV3_RECIP);
      e        = dm.quo[4:0];
      even_add = 10'd3;
      odd_add  = 10'd2;
    end else if (x < 14'd1008) begin
      d        = x - 14'd864;
      e        = nine_group(d[9:0]);
      even_add = 10'd3;
      odd_add  = 10'd2;
    end else begin
      d        = x - 14'd1008;
      e        = nine_group(d[9:0]);
      even_add = 10'd3;
      odd_add  = 10'd2;
    end
    if (pair) begin
      fwd_tc = (({5'd0, e} * 10'd5) >> 1) + (e[0] ? odd_add : even_add);
    end
  end

  // Barrel: twelve rings by thirty-six sectors of four crystals
  always_comb begin
    logic [13:0] b;
    logic [10:0] q;
    divmod_t     dm;
    logic [5:0]  rem36;
    b      = x - FWD_END;
    q      = b[12:2];
    dm     = divmod_small({1'b0, q[10:2]}, DIV9, DIV9_RECIP);
    rem36  = {dm.rem, q[1:0]};
    bar_tc = {4'd0, rem36} * 10'd12 + 10'd81 + {2'd0, dm.quo[9:2]};
  end

  // Backward endcap
  always_comb begin
    logic [13:0] d;
    divmod_t     dm;
    logic [4:0]  e;
    logic        inner;
    d     = '0;
    dm    = '0;
    e     = '0;
    inner = 1'b0;
    if (x < 14'd7920) begin
      d = x - BAR_END;
      e = nine_group(d[9:0]);
    end else if (x < 14'd8064) begin
      d = x - 14'd7920;
      e = nine_group(d[9:0]);
    end else if (x < 14'd8256) begin
      d  = x - 14'd8064;
      dm = divmod_small(d[9:0], DIV3, DIV3_RECIP);
      e  = dm.quo[4:0];
    end else if (x < 14'd8544) begin
      d     = x - 14'd8256;
      dm    = divmod_small(d[9:0], DIV3, DIV3_RECIP);
      e     = dm.quo[4:0];
      inner = 1'b1;
    end else begin
      d     = x - 14'd8544;
      e     = d[5:1];
      inner = 1'b1;
    end
    if (e[0]) begin
      bwd_tc = {4'd0, e, 1'b0} + 10'd513 - (inner ? 10'd2 : 10'd1);
    end else begin
      bwd_tc = {4'd0, e, 1'b0} + 10'd513 + (inner ? 10'd3 : 10'd2);
    end
  end

  // Sub-group bit, worked on the one-based crystal number
  logic [13:0] id_a, id_b, id_c, id_d, id_e, id_f, id_g, id_h;
  divmod_t     sm_a, sm_b, sm_c, sm_d, sm_e, sm_f;
  logic [3:0]  ra, rc, rd, re, rf;

  assign id_a = crystal_id - 14'd385;
  assign id_b = crystal_id - 14'd771;
  assign id_c = crystal_id - 14'd864;
  assign id_d = crystal_id - 14'd1009;
  assign id_e = crystal_id - 14'd7923;
  assign id_f = crystal_id - 14'd8450;
  assign id_g = crystal_id - 14'd97;
  assign id_h = crystal_id - 14'd1153;
  assign sm_a = divmod_small(id_a[9:0], DIV3, DIV3_RECIP);
  assign sm_b = divmod_small(id_b[9:0], DIV3, DIV3_RECIP);
  assign sm_c = divmod_small(id_c[9:0], DIV9, DIV9_RECIP);
  assign sm_d = divmod_small(id_d[9:0], DIV9, DIV9_RECIP);
  assign sm_e = divmod_small(id_e[9:0], DIV9, DIV9_RECIP);
  assign sm_f = divmod_small(id_f[9:0], DIV3, DIV3_RECIP);
  assign ra   = sm_a.rem;
  assign rc   = sm_c.rem;
  assign rd   = sm_d.rem;
  assign re   = sm_e.rem;
  assign rf   = sm_f.rem;

  always_comb begin
    if (crystal_id <= 14'd96)        sub_bit = 1'b1;
    else if (crystal_id <= 14'd160)  sub_bit = id_g[0] ^ id_g[1];
    else if (crystal_id <= 14'd224)  sub_bit = 1'b0;
    else if (crystal_id <= 14'd384)  sub_bit = 1'b1;
    else if (crystal_id <= 14'd480)  sub_bit = (ra == 4'd1);
    else if (crystal_id <= 14'd672)  sub_bit = 1'b0;
    else if (crystal_id <= 14'd770)  sub_bit = 1'b1;
    else if (crystal_id <= 14'd863)  sub_bit = sm_b.quo[0];
    else if (crystal_id <= 14'd1007) begin
      sub_bit = (rc == 4'd0) || (rc == 4'd1) || (rc == 4'd4) || (rc == 4'd7);
    end
    else if (crystal_id <= 14'd1008) sub_bit = 1'b1;
    else if (crystal_id <= 14'd1152) sub_bit = (rd == 4'd0);
    else if (crystal_id <= 14'd7488) sub_bit = ~id_h[1];
    else if (crystal_id <= 14'd7776) sub_bit = 1'b1;
    else if (crystal_id <= 14'd7922) sub_bit = 1'b0;
    else if (crystal_id <= 14'd8061) begin
      sub_bit = (re == 4'd0) || (re == 4'd1) || (re == 4'd5) || (re == 4'd6);
    end
    else if (crystal_id <= 14'd8062) sub_bit = 1'b0;
    else if (crystal_id <= 14'd8256) sub_bit = 1'b1;
    else if (crystal_id <= 14'd8449) sub_bit = 1'b0;
    else if (crystal_id <= 14'd8542) sub_bit = (rf < 4'd2);
    else                             sub_bit = 1'b1;
  end

  // Select the region; zero everything on an out-of-range number
  always_comb begin
    cell_res.range_error = err;
    if (err) begin
      cell_res.cell_id   = '0;
      cell_res.sub_index = 1'b0;
    end else begin
      cell_res.sub_index = sub_bit;
      if (x < FWD_END)      cell_res.cell_id = fwd_tc;
      else if (x < BAR_END) cell_res.cell_id = bar_tc;
      else                  cell_res.cell_id = bwd_tc;
    end
  end

endmodule

>>> hdl/ctcm_ring_calc.sv
// Trigger cell number to polar ring index and azimuthal sector index.
// Depends on ctcm_pkg.
module ctcm_ring_calc import ctcm_pkg::*; (
  input  cell_t      cell_res,
  output logic [4:0] theta_index,
  output logic [5:0] phi_index
);

  always_comb begin
    logic [9:0] t0;
    logic [9:0] v;
    logic [9:0] w;
    logic [9:0] w1;
    logic [5:0] h;
    logic [2:0] r;
    divmod_t    dm;
    t0 = cell_res.cell_id - 10'd1;
    v  = t0 - 10'd80;
    w  = t0 - 10'd512;
    w1 = t0 - 10'd513;
    h  = w[6:1];
    r  = '0;
    dm = '0;
    if (cell_res.range_error) begin
      theta_index = '0;
      phi_index   = '0;
    end else if (t0 < 10'd80) begin
      // forward endcap: five cells per pair of sectors
      dm          = divmod_small(t0, DIV5, DIV5_RECIP);
      r           = dm.rem[2:0];
      theta_index = (r < 3'd3) ? {2'd0, r} : {2'd0, 3'd5 - r};
      phi_index   = {dm.quo[4:0], (r >= 3'd3)};
    end else if (t0 < 10'd512) begin
      // barrel: twelve rings per sector, divide by four then by three
      dm          = divmod_small({3'd0, v[8:2]}, DIV3, DIV3_RECIP);
      theta_index = {1'b0, dm.rem[1:0], v[1:0]} + 5'd3;
      phi_index   = dm.quo[5:0];
    end else begin
      // backward endcap: swap neighboring sectors
      if (t0 == 10'd512) theta_index = 5'd16;
      else               theta_index = w1[1] ? 5'd16 : 5'd15;
      phi_index = h ^ 6'd1;
    end
  end

endmodule

>>> sim/tb_crystal_to_trigger_cell_map_unit.sv
// Testbench for crystal_to_trigger_cell_map_unit: predicts the trigger cell, sub-group bit,
// theta and phi ring indexes of every crystal transfer and checks each output transfer in order.
// Depends on ctcm_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module tb_crystal_to_trigger_cell_map_unit;
  import ctcm_pkg::N_CRYSTALS;
  import ctcm_pkg::FWD_END;
  import ctcm_pkg::BAR_END;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [13:0] crystal_id;
    logic [9:0]  cell_id;
    logic        sub_index;
    logic [4:0]  theta_index;
    logic [5:0]  phi_index;
    logic        range_error;
  } cell_map_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [13:0] in_crystal_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_cell_id;
  logic        out_sub_index;
  logic [4:0]  out_theta_index;
  logic [5:0]  out_phi_index;
  logic        out_range_error;

  cell_map_t pending_maps [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_len = 0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_left = 0;

  // First crystal of each ring group, used to aim random picks at the seams
  int unsigned ring_starts [22] = '{49, 97, 161, 225, 289, 385, 481, 673, 771, 865, 1009,
                                    1153, 7489, 7777, 7921, 7923, 8063, 8065, 8257, 8450,
                                    8545, 8736};

  crystal_to_trigger_cell_map_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_crystal_id   (in_crystal_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_id     (out_cell_id),
    .out_sub_index   (out_sub_index),
    .out_theta_index (out_theta_index),
    .out_phi_index   (out_phi_index),
    .out_range_error (out_range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring rule with a period of nine crystals: groups of five then four
  function automatic int unsigned ring_nine(input int unsigned d);
    return (d / 9) * 2 + ((d % 9) >= 5 ? 1 : 0);
  endfunction

  function automatic int unsigned fwd_ring_cell(input int unsigned x);
    int unsigned e;
    int unsigned even_add;
    int unsigned odd_add;
    if (x < 48) return (x / 3) * 5 + 1;
    if (x < 96) return ((x - 48) / 3) * 5 + 1;
    if (x < 160) return ((x - 96) / 4) * 5 + 1;
    if (x < 224) return ((x - 160) / 4) * 5 + 1;
    if (x < 288) begin
      e = (x - 224) / 2; even_add = 2; odd_add = 3;
    end else if (x < 672) begin
      e = ((x - 288) % 96) / 3; even_add = 2; odd_add = 3;
    end else if (x < 864) begin
      e = ((x - 672) % 96) / 3; even_add = 3; odd_add = 2;
    end else if (x < 1008) begin
      e = ring_nine(x - 864); even_add = 3; odd_add = 2;
    end else begin
      e = ring_nine(x - 1008); even_add = 3; odd_add = 2;
    end
    return (e * 5) / 2 + ((e & 1) != 0 ? odd_add : even_add);
  endfunction

  function automatic int unsigned bwd_ring_cell(input int unsigned x);
    int unsigned e;
    bit          inner;
    if (x < 7920) begin
      e = ring_nine(x - 7776); inner = 1'b0;
    end else if (x < 8064) begin
      e = ring_nine(x - 7920); inner = 1'b0;
    end else if (x < 8256) begin
      e = ((x - 8064) % 96) / 3; inner = 1'b0;
    end else if (x < 8544) begin
      e = ((x - 8256) % 96) / 3; inner = 1'b1;
    end else begin
      e = ((x - 8544) % 64) / 2; inner = 1'b1;
    end
    if ((e & 1) != 0) return e * 2 + 513 - (inner ? 2 : 1);
    return e * 2 + 513 + (inner ? 3 : 2);
  endfunction

  // Which half of its trigger cell a crystal falls in (one-based crystal number)
  function automatic logic crystal_half(input int unsigned id);
    int unsigned a;
    if (id <= FWD_END) begin
      if (id <= 96) return 1'b1;
      if (id <= 160) begin
        a = (id - 97) % 4;
        return (a == 0 || a == 3) ? 1'b0 : 1'b1;
      end
      if (id <= 224) return 1'b0;
      if (id <= 384) return 1'b1;
      if (id <= 480) return ((id - 385) % 3) == 1;
      if (id <= 672) return 1'b0;
      if (id <= 770) return 1'b1;
      if (id <= 863) return (((id - 771) % 6) / 3) != 0;
      if (id <= 1007) begin
        a = (id - 864) % 9;
        return a == 0 || a == 1 || a == 4 || a == 7;
      end
      if (id <= 1008) return 1'b1;
      return ((id - 1009) % 9) == 0;
    end
    if (id <= BAR_END) begin
      if (id <= 7488) return ((id - 1153) % 4) < 2;
      return 1'b1;
    end
    if (id <= 7922) return 1'b0;
    if (id <= 8061) begin
      a = (id - 7923) % 9;
      return a == 0 || a == 1 || a == 5 || a == 6;
    end
    if (id <= 8062) return 1'b0;
    if (id <= 8256) return 1'b1;
    if (id <= 8449) return 1'b0;
    if (id <= 8542) return ((id - 8450) % 3) < 2;
    return 1'b1;
  endfunction

  // Full mapping of one crystal number to its cell, half, theta and phi
  function automatic cell_map_t map_crystal(input logic [13:0] crystal);
    cell_map_t   m;
    int unsigned n;
    int unsigned x;
    int unsigned q;
    int unsigned tc;
    int unsigned t0;
    int unsigned r;
    int unsigned h;
    int unsigned th;
    int unsigned ph;
    m = '0;
    m.crystal_id = crystal;
    n = crystal;
    if (n < 1 || n > N_CRYSTALS) begin
      m.range_error = 1'b1;
      return m;
    end
    x = n - 1;
    if (x < FWD_END) begin
      tc = fwd_ring_cell(x);
    end else if (x < BAR_END) begin
      q = (x - FWD_END) / 4;
      tc = (q % 36) * 12 + 81 + q / 144;
    end else begin
      tc = bwd_ring_cell(x);
    end
    t0 = tc - 1;
    if (t0 < 80) begin
      r = t0 % 5;
      th = (r < 3) ? r : 5 - r;
      ph = (t0 / 5) * 2 + ((r < 3) ? 0 : 1);
    end else if (t0 < 512) begin
      th = (t0 - 80) % 12 + 3;
      ph = (t0 - 80) / 12;
    end else begin
      h = (t0 - 512) / 2;
      if (t0 == 512) th = 16;
      else th = ((((t0 - 513) / 2) & 1) != 0) ? 16 : 15;
      ph = ((h & 1) != 0) ? h - 1 : h + 1;
    end
    m.cell_id = 10'(tc);
    m.sub_index = crystal_half(n);
    m.theta_index = 5'(th);
    m.phi_index = 6'(ph);
    return m;
  endfunction

  // Offer one crystal, with a random idle gap first, and hold it until the transfer
  task automatic send_crystal(input logic [13:0] crystal);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_crystal_id <= crystal;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly valid crystals, a share aimed at ring seams, some out of range
  function automatic logic [13:0] pick_crystal();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) return 14'($urandom_range(16383, 8737));
    if (sel < 8) return 14'd0;
    if (sel < 30) return 14'(ring_starts[$urandom_range(21)] + $urandom_range(6) - 3);
    return 14'($urandom_range(N_CRYSTALS, 1));
  endfunction

  task automatic test_boundary_crystals();
    int unsigned ids [24] = '{0, 1, 48, 49, 97, 161, 225, 289, 673, 865, 1009, 1152, 1153,
                              7488, 7489, 7776, 7777, 7921, 8065, 8257, 8545, 8736, 8737,
                              16383};
    send_idle_pct = 0;
    stall_pct = 0;
    foreach (ids[i]) send_crystal(14'(ids[i]));
  endtask

  task automatic test_random_crystals(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_crystal(pick_crystal());
  endtask

  // Hold the output off for a long stretch while crystals keep coming
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 300;
    hold_req = hold_req + 1;
    repeat (40) send_crystal(14'($urandom_range(N_CRYSTALS, 1)));
  endtask

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left = hold_len;
      hold_ack = hold_req;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Record each input transfer, then check each output transfer against the oldest one
  always @(posedge clk) begin
    cell_map_t want;
    cell_map_t got;
    if (rst_n) begin
      if (in_valid && in_ready) pending_maps.push_back(map_crystal(in_crystal_id));
      if (out_valid && out_ready) begin
        if (pending_maps.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected output transfer: cell %0d sub %0d theta %0d phi %0d err %0d",
                     out_cell_id, out_sub_index, out_theta_index, out_phi_index,
                     out_range_error);
        end else begin
          want = pending_maps.pop_front();
          got.crystal_id = want.crystal_id;
          got.cell_id = out_cell_id;
          got.sub_index = out_sub_index;
          got.theta_index = out_theta_index;
          got.phi_index = out_phi_index;
          got.range_error = out_range_error;
          if (got !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("crystal %0d: expected cell %0d sub %0d theta %0d phi %0d err %0d,",
                       want.crystal_id, want.cell_id, want.sub_index, want.theta_index,
                       want.phi_index, want.range_error);
              $display("  got cell %0d sub %0d theta %0d phi %0d err %0d",
                       got.cell_id, got.sub_index, got.theta_index, got.phi_index,
                       got.range_error);
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_boundary_crystals();
    test_random_crystals(240, 0, 0);
    test_random_crystals(240, 66, 0);
    test_random_crystals(240, 0, 66);
    test_output_hold();
    test_random_crystals(230, 23, 23);

    // Drop valid, let the last transfer be recorded, drain, then let a few more cycles pass
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
